FILE: src/timer_prescaler_period_search_top_macros.svh
// ----------------------------------------------------------------------------
// timer_prescaler_period_search_top_macros.svh
// Assertion macros for the timer prescaler period search block.
// ----------------------------------------------------------------------------
`ifndef TIMER_PRESCALER_PERIOD_SEARCH_TOP_MACROS_SVH
`define TIMER_PRESCALER_PERIOD_SEARCH_TOP_MACROS_SVH

// a implies b in the same cycle
`define TPS_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error(msg);

// a implies b, with b checked after the delay n
`define TPS_ASSERT_AFTER(label, clk, rst_n, a, n, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
		else $error(msg);

`endif

FILE: src/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Types and constants shared by the timer prescaler period search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tps_pkg;

	localparam int CLK_W        = 32;
	localparam int FREQ_W       = 16;
	localparam int PERIOD_W     = 16;
	localparam int PERIOD_WIDTH = 16;
	localparam int CODE_W       = 3;
	localparam int PRE_NUM      = 7;
	localparam int ERR_W        = 11;
	localparam int DIV_STAGES   = CLK_W;
	localparam int LATENCY      = DIV_STAGES + 1;

	localparam logic [CLK_W-1:0]  CLOCK_RESET  = 32'd32000000;
	localparam logic [CODE_W-1:0] CODE_DEFAULT = 3'd1;
	localparam logic [CLK_W:0]    MAX_QUOT     = (CLK_W + 1)'(1) << PERIOD_WIDTH;

	// log2 of the prescalers 1, 2, 4, 8, 64, 256, 1024
	localparam int PRE_SHIFT [PRE_NUM] = '{0, 1, 2, 3, 6, 8, 10};

	typedef struct packed {
		logic              valid;
		logic              bad;
		logic [FREQ_W-1:0] divisor;
		logic [FREQ_W-1:0] rem;
		logic [CLK_W-1:0]  num;
		logic [CLK_W-1:0]  quo;
	} div_stage_t;

	typedef struct packed {
		logic                done;
		logic                bad;
		logic [CODE_W-1:0]   code;
		logic [PERIOD_W-1:0] period;
	} result_t;

	function automatic logic [ERR_W-1:0] err_mask(input int shift);
		return (ERR_W'(1) << shift) - ERR_W'(1);
	endfunction

endpackage

`default_nettype wire

FILE: src/timer_prescaler_period_search_top.sv
// ----------------------------------------------------------------------------
// timer_prescaler_period_search_top
// Picks the timer prescaler and period closest to a wanted tick frequency.
// ----------------------------------------------------------------------------
// An accepted start reaches the done strobe through the divider cells and the select register.
// Throughput: one request per cycle; busy is always low.
// A chain of 32 divider cells retires one quotient bit each, then one
// register scores the prescalers. Results cannot be stalled.
// Reset clears the pipeline valids and loads core_clock_hz with 32000000.
`timescale 1ns / 1ps
`default_nettype none
`include "timer_prescaler_period_search_top_macros.svh"

module timer_prescaler_period_search_top (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           core_clock_hz_we,
	input  wire  [tps_pkg::CLK_W-1:0]     core_clock_hz_wdata,
	input  wire                           start,
	output logic                          busy,
	input  wire  [tps_pkg::FREQ_W-1:0]    wanted_frequency,
	output logic                          done,
	output logic [tps_pkg::CODE_W-1:0]    clock_select,
	output logic [tps_pkg::PERIOD_W-1:0]  period,
	output logic                          bad_frequency
);
	import tps_pkg::*;

	logic [CLK_W-1:0] core_clock_q;
	div_stage_t       chain [DIV_STAGES+1];
	result_t          result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_clock_q <= CLOCK_RESET;
		end else if (core_clock_hz_we) begin
			core_clock_q <= core_clock_hz_wdata;
		end
	end

	assign busy = 1'b0;

	always_comb begin
		chain[0].valid   = start;
		chain[0].bad     = wanted_frequency == '0;
		chain[0].divisor = wanted_frequency;
		chain[0].rem     = '0;
		chain[0].num     = core_clock_q;
		chain[0].quo     = '0;
	end

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_cell
		tps_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_in  (chain[g]),
			.stage_out (chain[g+1])
		);
	end

	tps_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage_in (chain[DIV_STAGES]),
		.result   (result)
	);

	assign done          = result.done;
	assign clock_select  = result.code;
	assign period        = result.period;
	assign bad_frequency = result.bad;

	`TPS_ASSERT_NOW(a_code_nonzero, clk, arst_n, done, clock_select != '0, "zero clock select")
	`TPS_ASSERT_NOW(a_bad_default, clk, arst_n, done && bad_frequency,
		clock_select == CODE_DEFAULT && period == '0, "bad request not defaulted")
	`TPS_ASSERT_AFTER(a_bad_latency, clk, arst_n, start && wanted_frequency == '0, LATENCY,
		done && bad_frequency, "zero frequency request lost")
	`TPS_ASSERT_AFTER(a_good_latency, clk, arst_n, start && wanted_frequency != '0, LATENCY,
		done && !bad_frequency, "request lost")

endmodule

`default_nettype wire

FILE: src/tps_div_cell.sv
// ----------------------------------------------------------------------------
// tps_div_cell
// One restoring division step: retires one quotient bit per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tps_div_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tps_pkg::div_stage_t stage_in,
	output tps_pkg::div_stage_t stage_out
);
	import tps_pkg::*;

	logic [FREQ_W:0]   trial;
	logic              take;
	logic [FREQ_W-1:0] rem_next;

	always_comb begin
		trial    = {stage_in.rem, stage_in.num[CLK_W-1]};
		take     = trial >= {1'b0, stage_in.divisor};
		rem_next = take ? FREQ_W'(trial - {1'b0, stage_in.divisor}) : trial[FREQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_out <= '0;
		end else begin
			stage_out.valid   <= stage_in.valid;
			stage_out.bad     <= stage_in.bad;
			stage_out.divisor <= stage_in.divisor;
			stage_out.rem     <= rem_next;
			stage_out.num     <= {stage_in.num[CLK_W-2:0], 1'b0};
			stage_out.quo     <= {stage_in.quo[CLK_W-2:0], take};
		end
	end

endmodule

`default_nettype wire

FILE: src/tps_select.sv
// ----------------------------------------------------------------------------
// tps_select
// Scores the seven prescalers against the tick count and registers the best.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tps_select (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tps_pkg::div_stage_t stage_in,
	output tps_pkg::result_t    result
);
	import tps_pkg::*;

	logic [CLK_W-1:0]    ticks;
	logic [CLK_W-1:0]    quot;
	logic [ERR_W-1:0]    err;
	logic [ERR_W-1:0]    best_err;
	logic                found;
	logic [CODE_W-1:0]   best_code;
	logic [PERIOD_W-1:0] best_period;

	always_comb begin
		ticks       = stage_in.quo;
		quot        = '0;
		err         = '0;
		best_err    = '0;
		found       = 1'b0;
		best_code   = CODE_DEFAULT;
		best_period = '0;
		for (int i = 0; i < PRE_NUM; i++) begin
			quot = ticks >> PRE_SHIFT[i];
			err  = ticks[ERR_W-1:0] & err_mask(PRE_SHIFT[i]);
			if (quot != '0 && {1'b0, quot} <= MAX_QUOT && (!found || err < best_err)) begin
				found       = 1'b1;
				best_err    = err;
				best_code   = CODE_W'(i + 1);
				best_period = PERIOD_W'(quot - CLK_W'(1));
			end
		end
		if (stage_in.bad) begin
			best_code   = CODE_DEFAULT;
			best_period = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result <= '0;
		end else begin
			result.done   <= stage_in.valid;
			result.bad    <= stage_in.bad;
			result.code   <= best_code;
			result.period <= best_period;
		end
	end

endmodule

`default_nettype wire

FILE: tb/timer_prescaler_period_search_top_tb.sv
// ----------------------------------------------------------------------------
// timer_prescaler_period_search_top_tb
// Self-checking bench for the prescaler and period search. Each accepted
// request is scored by a local predictor that tries all seven prescalers
// against the current source clock. The expected setting is queued and
// compared field by field with each done strobe. Directed requests cover
// zero frequency, exact fits, ties and the nothing-fits cases at extreme
// source clocks. Random traffic follows, under several sender idle rates and
// clock settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timer_prescaler_period_search_top_tb;

	import tps_pkg::*;

	localparam int TAIL_CYCLES = 40;   // pipeline is 33 deep
	localparam int SEG_ITEMS   = 72;
	localparam logic [6:0][3:0] DIV_LOG2 = {4'd10, 4'd8, 4'd6, 4'd3, 4'd2, 4'd1, 4'd0};

	typedef struct {
		logic [CLK_W-1:0]    src_hz;
		logic [FREQ_W-1:0]   freq;
		logic [CODE_W-1:0]   code;
		logic [PERIOD_W-1:0] per;
		logic                bad;
	} tick_setting_t;

	logic                clk;
	logic                arst_n;
	logic                core_clock_hz_we;
	logic [CLK_W-1:0]    core_clock_hz_wdata;
	logic                start;
	logic                busy;
	logic [FREQ_W-1:0]   wanted_frequency;
	logic                done;
	logic [CODE_W-1:0]   clock_select;
	logic [PERIOD_W-1:0] period;
	logic                bad_frequency;

	tick_setting_t    pending_settings [$];
	logic [CLK_W-1:0] src_clock_hz;
	int               fail_count;

	timer_prescaler_period_search_top i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.core_clock_hz_we    (core_clock_hz_we),
		.core_clock_hz_wdata (core_clock_hz_wdata),
		.start               (start),
		.busy                (busy),
		.wanted_frequency    (wanted_frequency),
		.done                (done),
		.clock_select        (clock_select),
		.period              (period),
		.bad_frequency       (bad_frequency)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic tick_setting_t pick_prescaler(input logic [CLK_W-1:0] src_hz,
			input logic [FREQ_W-1:0] freq);
		tick_setting_t    s;
		logic [CLK_W-1:0] ticks;
		logic [CLK_W-1:0] quot;
		logic [CLK_W-1:0] err;
		logic [CLK_W-1:0] best_err;
		int               best_sel;
		s.src_hz = src_hz;
		s.freq   = freq;
		s.code   = CODE_DEFAULT;
		s.per    = '0;
		s.bad    = 1'b0;
		if (freq == '0) begin
			s.bad = 1'b1;
			return s;
		end
		ticks    = src_hz / {16'd0, freq};
		best_err = '1;
		best_sel = 0;
		for (int i = 0; i < 7; i++) begin
			quot = ticks >> DIV_LOG2[i];
			if (quot == '0)
				continue;
			if ({1'b0, quot} > (33'd1 << PERIOD_WIDTH))
				continue;
			err = ticks - (quot << DIV_LOG2[i]);
			if (err < best_err) begin
				best_err = err;
				best_sel = i;
				s.per    = PERIOD_W'(quot - 1);
			end
		end
		s.code = CODE_W'(best_sel + 1);
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin : check_results
		tick_setting_t s;
		if (arst_n && done) begin
			if (pending_settings.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				s = pending_settings.pop_front();
				if (clock_select !== s.code)
					report_mismatch($sformatf("clk %0d freq %0d: clock_select %0d exp %0d",
						s.src_hz, s.freq, clock_select, s.code));
				if (period !== s.per)
					report_mismatch($sformatf("clk %0d freq %0d: period %0d exp %0d",
						s.src_hz, s.freq, period, s.per));
				if (bad_frequency !== s.bad)
					report_mismatch($sformatf("clk %0d freq %0d: bad_frequency %0b exp %0b",
						s.src_hz, s.freq, bad_frequency, s.bad));
			end
		end
	end

	task automatic send_request(input logic [FREQ_W-1:0] freq);
		@(negedge clk);
		start            <= 1'b1;
		wanted_frequency <= freq;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_settings.push_back(pick_prescaler(src_clock_hz, freq));
	endtask

	task automatic idle_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start            <= 1'b0;
			wanted_frequency <= FREQ_W'($urandom());
		end
	endtask

	task automatic wait_drain();
		idle_sender(1);
		while (pending_settings.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_clock(input logic [CLK_W-1:0] hz);
		wait_drain();
		@(negedge clk);
		core_clock_hz_we    <= 1'b1;
		core_clock_hz_wdata <= hz;
		@(negedge clk);
		core_clock_hz_we    <= 1'b0;
		src_clock_hz = hz;
	endtask

	function automatic logic [FREQ_W-1:0] random_freq();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 5)
			return '0;
		if (sel < 35)
			return FREQ_W'($urandom_range(1, 256));
		if (sel < 45)
			return FREQ_W'($urandom_range(0, 15)) | 16'hFFF0;
		return FREQ_W'($urandom());
	endfunction

	function automatic logic [CLK_W-1:0] random_clock();
		case ($urandom_range(5))
			0: return CLOCK_RESET;
			1: return 32'hFFFF_FFFF;
			2: return 32'd1;
			3: return $urandom_range(1, 1 << 20);
			4: return $urandom_range(1 << 20, 1 << 28);
			default: return $urandom();
		endcase
	endfunction

	task automatic test_reset_clock();
		send_request(16'd0);
		send_request(16'd1);
		send_request(16'd2);
		send_request(16'd488);
		send_request(16'd1000);
		send_request(16'd32768);
		send_request(16'h5555);
		send_request(16'hFFFF);
	endtask

	task automatic test_clock_extremes();
		write_clock(32'hFFFF_FFFF);
		send_request(16'd1);
		send_request(16'd0);
		send_request(16'hAAAA);
		send_request(16'hFFFF);
		write_clock(32'd0);
		send_request(16'd1);
		send_request(16'hFFFF);
		write_clock(32'd1);
		send_request(16'd1);
		send_request(16'd2);
		send_request(16'hFFFF);
		write_clock(32'd65536);
		send_request(16'd1);
		send_request(16'd2);
	endtask

	task automatic test_drain_pause();
		write_clock(CLOCK_RESET);
		repeat (4)
			send_request(random_freq());
		wait_drain();
		repeat (4)
			send_request(random_freq());
	endtask

	task automatic test_random_traffic(input int idle_pct);
		repeat (3) begin
			write_clock(random_clock());
			repeat (SEG_ITEMS) begin
				send_request(random_freq());
				while ($urandom_range(99) < idle_pct)
					idle_sender(1);
			end
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		start               = 1'b0;
		wanted_frequency    = '0;
		core_clock_hz_we    = 1'b0;
		core_clock_hz_wdata = '0;
		src_clock_hz        = CLOCK_RESET;
		fail_count          = 0;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_clock();
		test_clock_extremes();
		test_drain_pause();
		test_random_traffic(0);
		test_random_traffic(45);
		test_random_traffic(37);
		wait_drain();

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
